FILE: design/mrm_pkg.sv
// shared types and constants for the multichannel running median block
// no dependencies; imported by mrm_history and multichannel_running_median
package mrm_pkg;

	localparam int CHANNELS   = 8;
	localparam int WINDOW_MAX = 32;
	localparam int SAMPLE_W   = 24;
	localparam int CH_W       = $clog2(CHANNELS);
	localparam int PTR_W      = $clog2(WINDOW_MAX);
	localparam int CNT_W      = PTR_W + 1;
	localparam int WIN_REG_W  = 6;
	localparam int AMB_W      = 24;
	localparam int SCALE_W    = 24;
	localparam int MASK_W     = 8;
	localparam int IDX_W      = 2;
	localparam int CFG_W      = 24;
	localparam int DELTA_W    = 32;
	localparam int FRAC_BITS  = 12;
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int PROD_W     = DIFF_W + SCALE_W;
	localparam int SHR_W      = PROD_W - FRAC_BITS;

	// -200 degrees in 1/256 degree units
	localparam logic signed [SAMPLE_W-1:0] BAD_LIMIT = SAMPLE_W'(-51200);

	localparam logic [WIN_REG_W-1:0] WINDOW_RESET = WIN_REG_W'(1);
	localparam logic [SCALE_W-1:0]   SCALE_RESET  = SCALE_W'(4096);

	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW_SIZE,
		REG_AMBIENT_LEVEL,
		REG_DELTA_SCALE,
		REG_DUMMY_MASK
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_CAND_RD,
		ST_CAND_LD,
		ST_SCAN,
		ST_DECIDE,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] row_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		row_t             row;
	} hist_wr_t;

endpackage

FILE: design/mrm_history.sv
// sample history: one row per window slot, all channels side by side
// depends on mrm_pkg; rows never written since reset read as zero
module mrm_history (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mrm_pkg::hist_wr_t     wr,
	input  logic [mrm_pkg::PTR_W-1:0] rd_addr,
	output mrm_pkg::row_t         rd_row
);
	import mrm_pkg::*;

	row_t                  mem_q [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] vld_q;
	row_t                  rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.row;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_row = rd_vld_q ? rd_q : '0;

endmodule

FILE: design/multichannel_running_median.sv
// top level of the eight channel running median filter
// depends on mrm_pkg and mrm_history
//
// Each accepted item writes one sample per channel into the history row at
// the write pointer, then the block returns eight result items, channel 0
// first. The median is found by rank selection with a single comparator
// and one history read port: each candidate entry is compared against all
// n stored entries of its channel (n = current sample count); the first
// candidate whose rank brackets n/2 wins. Output stalls hold the block in
// its emit step. After the window is shrunk, the pointer wrap is done by
// repeated subtraction. in_stall stays high until the last result has been
// loaded into the output register; that result may still wait on out_stall
// while the next item is accepted. Configuration is always ready; write it
// only while the block is idle. The history is cleared by valid flags at
// reset, so there is no clearing pass.
module multichannel_running_median (
	input  logic                           clk,
	input  logic                           arst_n,
	// item input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_ch0,
	input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_ch1,
	input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_ch2,
	input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_ch3,
	input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_ch4,
	input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_ch5,
	input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_ch6,
	input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_ch7,
	// result output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mrm_pkg::CH_W-1:0]       channel,
	output logic signed [mrm_pkg::SAMPLE_W-1:0] median_value,
	output logic signed [mrm_pkg::DELTA_W-1:0]  delta_value,
	output logic                           bad_sensor,
	output logic                           any_bad,
	output logic                           last_result,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mrm_pkg::IDX_W-1:0]      cfg_index,
	input  logic [mrm_pkg::CFG_W-1:0]      cfg_data
);
	import mrm_pkg::*;

	// configuration registers
	logic [WIN_REG_W-1:0]       win_reg_q;
	logic signed [AMB_W-1:0]    amb_q;
	logic signed [SCALE_W-1:0]  scale_q;
	logic [MASK_W-1:0]          dummy_q;

	// sequencer state
	state_t               state_q, state_d;
	logic [PTR_W-1:0]     wptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     wrap_q;
	logic [CH_W-1:0]      ch_q;
	logic [PTR_W-1:0]     cand_idx_q;
	logic [PTR_W-1:0]     scan_idx_q;
	logic [CNT_W-1:0]     lt_q;
	logic [CNT_W-1:0]     le_q;
	logic                 any_q;

	// datapath registers
	sample_t              cand_q;
	sample_t              med_q;
	logic signed [PROD_W-1:0] prod_q;

	// output register
	logic                 out_valid_q;
	logic [CH_W-1:0]      ch_out_q;
	sample_t              med_out_q;
	logic [DELTA_W-1:0]   delta_out_q;
	logic                 bad_out_q;
	logic                 any_out_q;
	logic                 last_out_q;

	// memory interface
	hist_wr_t             hist_wr;
	logic [PTR_W-1:0]     rd_addr;
	row_t                 rd_row;

	logic                 in_acc;
	logic                 cfg_acc;
	logic [CNT_W-1:0]     win;
	logic [CNT_W-1:0]     rank_k;
	logic [PTR_W-1:0]     last_idx;
	logic                 scan_last;
	logic                 cand_last;
	logic                 found;
	logic                 emit_ok;
	sample_t              rd_entry;
	logic                 cmp_lt;
	logic                 cmp_le;
	logic signed [DIFF_W-1:0] diff;
	logic signed [SHR_W-1:0]  shr;
	logic                 sat;
	logic [DELTA_W-1:0]   delta_sat;
	logic                 bad_now;

	mrm_history u_history (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (hist_wr),
		.rd_addr (rd_addr),
		.rd_row  (rd_row)
	);

	// effective window, clamped to 1..WINDOW_MAX
	always_comb begin
		if (win_reg_q == '0) begin
			win = CNT_W'(1);
		end else if (win_reg_q > WIN_REG_W'(WINDOW_MAX)) begin
			win = CNT_W'(WINDOW_MAX);
		end else begin
			win = CNT_W'(win_reg_q);
		end
	end

	assign in_acc   = in_valid && !in_stall;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign rank_k   = cnt_q >> 1;
	assign last_idx = PTR_W'(cnt_q - CNT_W'(1));
	assign scan_last = (scan_idx_q == last_idx);
	assign cand_last = (cand_idx_q == last_idx);

	// the shared comparator: one stored entry against the candidate
	assign rd_entry = $signed(rd_row[ch_q]);
	assign cmp_lt   = rd_entry < cand_q;
	assign cmp_le   = rd_entry <= cand_q;

	// candidate holds rank k when lt <= k < le
	assign found = (lt_q <= rank_k) && (rank_k < le_q);

	// delta: product rounded toward minus infinity, then saturated
	assign diff = DIFF_W'(med_q) - DIFF_W'(amb_q);
	assign shr  = prod_q[PROD_W-1:FRAC_BITS];
	assign sat  = (shr[SHR_W-1:DELTA_W-1] != '0) && (shr[SHR_W-1:DELTA_W-1] != '1);
	always_comb begin
		if (!sat) begin
			delta_sat = shr[DELTA_W-1:0];
		end else if (shr[SHR_W-1]) begin
			delta_sat = {1'b1, {(DELTA_W-1){1'b0}}};
		end else begin
			delta_sat = {1'b0, {(DELTA_W-1){1'b1}}};
		end
	end

	assign bad_now = (med_q <= BAD_LIMIT) && !dummy_q[ch_q];
	assign emit_ok = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: begin
				if (wrap_q < win) begin
					state_d = ST_CAND_RD;
				end
			end
			ST_CAND_RD: state_d = ST_CAND_LD;
			ST_CAND_LD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = found ? ST_MUL : ST_CAND_RD;
			ST_MUL:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_ok) begin
					state_d = (ch_q == CH_W'(CHANNELS - 1)) ? ST_IDLE : ST_CAND_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, history write and read address
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		hist_wr.en   = 1'b0;
		hist_wr.addr = wptr_q;
		hist_wr.row  = {sample_ch7, sample_ch6, sample_ch5, sample_ch4,
		                sample_ch3, sample_ch2, sample_ch1, sample_ch0};
		rd_addr      = cand_idx_q;
		case (state_q)
			ST_IDLE:    hist_wr.en = in_acc;
			ST_CAND_RD: rd_addr = cand_idx_q;
			ST_CAND_LD: rd_addr = '0;
			ST_SCAN:    rd_addr = scan_idx_q + PTR_W'(1);
			default:    rd_addr = cand_idx_q;
		endcase
	end

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_reg_q <= WINDOW_RESET;
			amb_q     <= '0;
			scale_q   <= SCALE_RESET;
			dummy_q   <= '0;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_WINDOW_SIZE:   win_reg_q <= cfg_data[WIN_REG_W-1:0];
				REG_AMBIENT_LEVEL: amb_q     <= $signed(cfg_data[AMB_W-1:0]);
				REG_DELTA_SCALE:   scale_q   <= $signed(cfg_data[SCALE_W-1:0]);
				REG_DUMMY_MASK:    dummy_q   <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wptr_q      <= '0;
			cnt_q       <= '0;
			wrap_q      <= '0;
			ch_q        <= '0;
			cand_idx_q  <= '0;
			scan_idx_q  <= '0;
			lt_q        <= '0;
			le_q        <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wrap_q     <= CNT_W'(wptr_q) + CNT_W'(1);
						cnt_q      <= (cnt_q < win) ? cnt_q + CNT_W'(1) : win;
						ch_q       <= '0;
						cand_idx_q <= '0;
						any_q      <= 1'b0;
					end
				end
				ST_WRAP: begin
					// pointer modulo window by repeated subtraction
					if (wrap_q >= win) begin
						wrap_q <= wrap_q - win;
					end else begin
						wptr_q <= wrap_q[PTR_W-1:0];
					end
				end
				ST_CAND_LD: begin
					scan_idx_q <= '0;
					lt_q       <= '0;
					le_q       <= '0;
				end
				ST_SCAN: begin
					lt_q <= lt_q + CNT_W'(cmp_lt);
					le_q <= le_q + CNT_W'(cmp_le);
					if (!scan_last) begin
						scan_idx_q <= scan_idx_q + PTR_W'(1);
					end
				end
				ST_DECIDE: begin
					if (!found) begin
						cand_idx_q <= cand_idx_q + PTR_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						any_q      <= any_q | bad_now;
						ch_q       <= ch_q + CH_W'(1);
						cand_idx_q <= '0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_CAND_LD) begin
			cand_q <= rd_entry;
		end
		if (state_q == ST_DECIDE) begin
			med_q <= cand_q;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(diff) * PROD_W'(scale_q);
		end
		if (state_q == ST_EMIT && emit_ok) begin
			ch_out_q    <= ch_q;
			med_out_q   <= med_q;
			delta_out_q <= delta_sat;
			bad_out_q   <= bad_now;
			last_out_q  <= (ch_q == CH_W'(CHANNELS - 1));
			any_out_q   <= (ch_q == CH_W'(CHANNELS - 1)) && (any_q | bad_now);
		end
	end

	assign out_valid    = out_valid_q;
	assign channel      = ch_out_q;
	assign median_value = med_out_q;
	assign delta_value  = $signed(delta_out_q);
	assign bad_sensor   = bad_out_q;
	assign any_bad      = any_out_q;
	assign last_result  = last_out_q;

	// sample count never passes the largest window
	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW_MAX))
		else $error("sample count above window maximum");

	// each candidate is counted against itself, so le always exceeds lt
	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> (le_q > lt_q))
		else $error("candidate not counted against itself");

	// the last candidate of a channel must be the median
	a_median_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && cand_last) |-> found)
		else $error("rank selection ran out of candidates");

	// any_bad is only raised on the last result of an item
	a_any_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_out_q) |-> !any_out_q)
		else $error("any_bad set before the last result");

	// an accepted item always starts with the pointer wrap step
	a_accept_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_WRAP))
		else $error("accepted item did not start processing");

endmodule
